// ----- design/hsa_pkg.sv -----
// Shared types, constants and helper functions of the HLS hue/saturation unit.
// Depends on nothing; every other design file imports it.
package hsa_pkg;

    // Channel divisor of the HLS-to-RGB conversion (85 * 255) and its reciprocal.
    // The reciprocal is ceil(2^32 / 21675); its quotient is high by at most one.
    localparam logic [14:0] CHAN_DEN   = 15'd21675;
    localparam logic [17:0] CHAN_RECIP = 18'd198154;

    // Divider geometry shared by the hue and saturation dividers.
    localparam int DivNumW = 17;
    localparam int DivDenW = 9;
    localparam int DivQuoW = 8;

    // Reset value of the saturation gain register.
    localparam logic signed [8:0] SAT_ADJ_RESET = 9'sd102;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_HUE_OFFSET = 2'd0,
        REG_LIGHTNESS  = 2'd1,
        REG_SATURATION = 2'd2
    } reg_idx_t;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic signed [8:0] hue_offset;
        logic signed [8:0] lightness_adjust;
        logic signed [8:0] saturation_adjust;
    } cfg_t;

    // One pixel in HLS form after adjustment.
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] light;
        logic [7:0] sat;
        logic       eof;
    } hls_pix_t;

    // Floor of x / 255 for x below 65280.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

// ----- design/hsa_rgb2hls.sv -----
// First stage: RGB to lightness plus the numerators and divisors of hue and saturation.
// Depends on hsa_pkg.
module hsa_rgb2hls
    import hsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    input  logic        in_eof,
    output logic        out_valid,
    output logic [16:0] sat_num,
    output logic [8:0]  sat_den,
    output logic [16:0] hue_num,
    output logic [8:0]  hue_den,
    output logic [7:0]  light,
    output logic        eof
);

    logic [7:0]         mx;
    logic [7:0]         mn;
    logic [8:0]         sum;
    logic [7:0]         d;
    logic [9:0]         kd;
    logic signed [9:0]  q;
    logic signed [11:0] t;
    logic signed [18:0] hn;
    logic               valid_reg;
    logic [16:0]        sat_num_reg, sat_num_next;
    logic [8:0]         sat_den_reg, sat_den_next;
    logic [16:0]        hue_num_reg, hue_num_next;
    logic [8:0]         hue_den_reg, hue_den_next;
    logic [7:0]         light_reg;
    logic               eof_reg;

    // Extremes, sector and raw quotient operands.
    always_comb
    begin
        mx = (in_red > in_green) ? in_red : in_green;
        if (in_blue > mx)
        begin
            mx = in_blue;
        end
        mn = (in_red < in_green) ? in_red : in_green;
        if (in_blue < mn)
        begin
            mn = in_blue;
        end
        sum = {1'b0, mx} + {1'b0, mn};
        d   = mx - mn;
        if (in_red == mx)
        begin
            kd = 10'd0;
            q  = $signed({2'b00, in_green}) - $signed({2'b00, in_blue});
        end
        else if (in_green == mx)
        begin
            kd = {1'b0, d, 1'b0};
            q  = $signed({2'b00, in_blue}) - $signed({2'b00, in_red});
        end
        else
        begin
            kd = {d, 2'b00};
            q  = $signed({2'b00, in_red}) - $signed({2'b00, in_green});
        end
        t  = $signed({2'b00, kd}) + $signed({{2{q[9]}}, q});
        hn = $signed({{7{t[11]}}, t}) * 19'sd85;
        if (hn < 0)
        begin
            hn = hn + $signed({2'b00, {9'd0, d} * 17'd510});
        end

        // A gray pixel has zero hue and saturation; a unit divisor keeps the dividers sane.
        if (d == 8'd0)
        begin
            sat_num_next = '0;
            sat_den_next = 9'd1;
            hue_num_next = '0;
            hue_den_next = 9'd1;
        end
        else
        begin
            sat_num_next = {9'd0, d} * 17'd255;
            sat_den_next = sum[8] ? (9'd511 - sum) : sum;
            hue_num_next = hn[16:0];
            hue_den_next = {d, 1'b0};
        end
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_num_reg <= sat_num_next;
            sat_den_reg <= sat_den_next;
            hue_num_reg <= hue_num_next;
            hue_den_reg <= hue_den_next;
            light_reg   <= sum[8:1];
            eof_reg     <= in_eof;
        end
    end

    assign out_valid = valid_reg;
    assign sat_num   = sat_num_reg;
    assign sat_den   = sat_den_reg;
    assign hue_num   = hue_num_reg;
    assign hue_den   = hue_den_reg;
    assign light     = light_reg;
    assign eof       = eof_reg;

endmodule

// ----- design/hsa_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side channel.
// Depends on hsa_pkg for its default geometry; the quotient must fit QUO_W bits.
module hsa_div
    import hsa_pkg::*;
#(
    parameter int NUM_W  = DivNumW,
    parameter int DEN_W  = DivDenW,
    parameter int QUO_W  = DivQuoW,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] out_side
);

    localparam int CmpW = NUM_W + DEN_W + QUO_W;

    logic [NUM_W-1:0]  rem_reg  [0:QUO_W];
    logic [NUM_W-1:0]  rem_next [1:QUO_W];
    logic [DEN_W-1:0]  den_reg  [0:QUO_W];
    logic [QUO_W-1:0]  quo_reg  [0:QUO_W];
    logic [QUO_W-1:0]  quo_next [1:QUO_W];
    logic [SIDE_W-1:0] side_reg [0:QUO_W];
    logic [QUO_W:0]    valid_reg;

    // One trial subtraction per stage, highest quotient bit first.
    always_comb
    begin
        logic [CmpW-1:0] trial;
        for (int k = 0; k < QUO_W; k++)
        begin
            trial = CmpW'(den_reg[k]) << (QUO_W - 1 - k);
            rem_next[k+1] = rem_reg[k];
            quo_next[k+1] = quo_reg[k];
            if (CmpW'(rem_reg[k]) >= trial)
            begin
                rem_next[k+1] = NUM_W'(CmpW'(rem_reg[k]) - trial);
                quo_next[k+1][QUO_W-1-k] = 1'b1;
            end
        end
    end

    // Valid bits travel with the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QUO_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            side_reg[0] <= in_side;
            for (int k = 1; k <= QUO_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_reg[k-1];
                quo_reg[k]  <= quo_next[k];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign quo       = quo_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

// ----- design/hsa_adjust.sv -----
// Two stages that apply hue offset, lightness scaling and saturation gain.
// Depends on hsa_pkg (cfg_t, hls_pix_t, div255).
module hsa_adjust
    import hsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  cfg_t     cfg,
    input  logic     in_valid,
    input  hls_pix_t in_pix,
    output logic     out_valid,
    output hls_pix_t out_pix
);

    logic signed [9:0] hue_sum;
    logic signed [8:0] la;
    logic signed [8:0] sa;
    logic [8:0]        sat_gain;
    logic [7:0]        lfac;
    logic [7:0]        lmul;
    logic [1:0]        valid_reg;
    logic [7:0]        hue_reg, hue_next;
    logic [7:0]        lbase_reg, lbase_next;
    logic [15:0]       lprod_reg, lprod_next;
    logic [16:0]       sprod_reg, sprod_next;
    logic              eof_reg;
    hls_pix_t          pix_reg, pix_next;

    // First stage: wrapped hue and the scaling products.
    always_comb
    begin
        hue_sum = $signed({2'b00, in_pix.hue}) + $signed({cfg.hue_offset[8], cfg.hue_offset});
        if (hue_sum < 0)
        begin
            hue_sum = hue_sum + 10'sd255;
        end
        else if (hue_sum > 10'sd255)
        begin
            hue_sum = hue_sum - 10'sd255;
        end
        hue_next = hue_sum[7:0];

        la = (cfg.lightness_adjust == -9'sd256) ? -9'sd255 : cfg.lightness_adjust;
        if (la < 0)
        begin
            lfac       = in_pix.light;
            lmul       = 8'(9'sd255 + la);
            lbase_next = 8'd0;
        end
        else
        begin
            lfac       = 8'd255 - in_pix.light;
            lmul       = la[7:0];
            lbase_next = in_pix.light;
        end
        lprod_next = lfac * lmul;

        sa         = (cfg.saturation_adjust == -9'sd256) ? -9'sd255 : cfg.saturation_adjust;
        sat_gain   = 9'(10'sd255 + {sa[8], sa});
        sprod_next = {9'd0, in_pix.sat} * {8'd0, sat_gain};
    end

    // Second stage: divide by 255 and clamp saturation.
    always_comb
    begin
        pix_next.hue   = hue_reg;
        pix_next.light = lbase_reg + div255(lprod_reg);
        pix_next.sat   = (sprod_reg >= 17'd65280) ? 8'd255 : div255(sprod_reg[15:0]);
        pix_next.eof   = eof_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg   <= hue_next;
            lbase_reg <= lbase_next;
            lprod_reg <= lprod_next;
            sprod_reg <= sprod_next;
            eof_reg   <= in_pix.eof;
            pix_reg   <= pix_next;
        end
    end

    assign out_valid = valid_reg[1];
    assign out_pix   = pix_reg;

endmodule

// ----- design/hsa_hls2rgb.sv -----
// Five stages that convert an adjusted HLS pixel back to RGB.
// Depends on hsa_pkg (hls_pix_t, CHAN_DEN, CHAN_RECIP).
module hsa_hls2rgb
    import hsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  hls_pix_t   in_pix,
    output logic       out_valid,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic       out_eof
);

    // Weight of (M2 - M1) for one channel; the middle band uses 85 so that
    // 85*M2 / 21675 equals M2 / 255.
    function automatic logic [6:0] chan_coef(input logic [7:0] h, input logic signed [7:0] off);
        logic signed [9:0] x;
        logic [7:0]        xu;
        logic [7:0]        span;
        x = $signed({2'b00, h}) + $signed({{2{off[7]}}, off});
        if (x > 10'sd255)
        begin
            x = x - 10'sd255;
        end
        else if (x < 0)
        begin
            x = x + 10'sd255;
        end
        xu   = x[7:0];
        span = 8'd170 - xu;
        if (xu <= 8'd42)
        begin
            return {xu[5:0], 1'b0};
        end
        else if (xu <= 8'd127)
        begin
            return 7'd85;
        end
        else if (xu <= 8'd169)
        begin
            return {span[5:0], 1'b0};
        end
        return 7'd0;
    endfunction

    logic [15:0]      p_ls;
    logic [16:0]      m2_next;
    logic [16:0]      m1_next;
    logic [4:0]       valid_reg;
    logic [16:0]      m2_reg;
    logic [7:0]       l_reg;
    logic [2:0][6:0]  coef1_reg;
    logic [2:0][6:0]  coef2_reg;
    logic [16:0]      m1_reg;
    logic [16:0]      diff_reg;
    logic [2:0][22:0] v3_reg;
    logic [2:0][22:0] v4_reg;
    logic [2:0][8:0]  q0_reg;
    logic [2:0][7:0]  rgb_reg;
    logic [4:0]       eof_reg;
    logic [2:0][22:0] v_next;
    logic [2:0][8:0]  q0_next;
    logic [2:0][7:0]  rgb_next;

    // First stage: M2 from lightness and saturation.
    always_comb
    begin
        p_ls = in_pix.light * in_pix.sat;
        if (!in_pix.light[7])
        begin
            m2_next = {9'd0, in_pix.light} * 17'd255 + {1'b0, p_ls};
        end
        else
        begin
            m2_next = {9'd0, in_pix.light} * 17'd255 + {9'd0, in_pix.sat} * 17'd255
                      - {1'b0, p_ls};
        end
    end

    // Second stage: M1 = 2L - M2 on the 65025 scale.
    assign m1_next = {9'd0, l_reg} * 17'd510 - m2_reg;

    // Third to fifth stages: weighted numerator, reciprocal estimate, correction.
    always_comb
    begin
        logic [40:0] prod;
        logic [23:0] chk;
        for (int c = 0; c < 3; c++)
        begin
            v_next[c]  = 23'(m1_reg) * 23'd85 + 23'(diff_reg) * 23'(coef2_reg[c]);
            prod       = 41'(v3_reg[c]) * 41'(CHAN_RECIP);
            q0_next[c] = prod[40:32];
            chk        = 24'(q0_reg[c]) * 24'(CHAN_DEN);
            rgb_next[c] = (chk > {1'b0, v4_reg[c]}) ? 8'(q0_reg[c] - 9'd1) : q0_reg[c][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_reg       <= m2_next;
            l_reg        <= in_pix.light;
            coef1_reg[0] <= chan_coef(in_pix.hue, 8'sd85);
            coef1_reg[1] <= chan_coef(in_pix.hue, 8'sd0);
            coef1_reg[2] <= chan_coef(in_pix.hue, -8'sd85);
            m1_reg       <= m1_next;
            diff_reg     <= m2_reg - m1_next;
            coef2_reg    <= coef1_reg;
            v3_reg       <= v_next;
            v4_reg       <= v3_reg;
            q0_reg       <= q0_next;
            rgb_reg      <= rgb_next;
            eof_reg      <= {eof_reg[3:0], in_pix.eof};
        end
    end

    assign out_valid = valid_reg[4];
    assign out_red   = rgb_reg[0];
    assign out_green = rgb_reg[1];
    assign out_blue  = rgb_reg[2];
    assign out_eof   = eof_reg[4];

endmodule

// ----- design/hls_hue_saturation_adjust_unit.sv -----
// HLS hue / lightness / saturation adjustment of an RGB pixel stream.
//
// The slave stream carries one pixel per transfer: tdata holds red, green and
// blue, tlast marks the last pixel of an image. The master stream returns the
// adjusted pixel in the same layout, with tlast copied through.
// The cfg channel writes the hue offset, lightness adjust and saturation
// adjust registers (indexes 0, 1, 2; other indexes are dropped). It is always
// ready; write it only while no pixel is in flight.
// An input transfer passes one stage of RGB-to-HLS, nine stages of the hue and
// saturation dividers (an input register, then one quotient bit per stage), two
// adjust stages and five HLS-to-RGB stages before its output beat. One pixel
// enters per cycle unless the output beat is held. The whole pipeline shares one
// enable, so when the receiver holds tready low with a beat waiting, every stage
// freezes and s_axis_tready drops; nothing is lost or repeated. Reset clears all
// valid bits and sets the registers to hue 0, lightness 0, saturation 102.
// Depends on hsa_pkg, hsa_rgb2hls, hsa_div, hsa_adjust and hsa_hls2rgb.
module hls_hue_saturation_adjust_unit
    import hsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_red [7:0], in_green [15:8], in_blue [23:16]
    input  logic        s_axis_tlast,   // end_of_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic        m_axis_tlast,   // frame_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    logic        en;
    cfg_t        cfg_reg;
    logic        s1_valid;
    logic [16:0] s1_sat_num;
    logic [8:0]  s1_sat_den;
    logic [16:0] s1_hue_num;
    logic [8:0]  s1_hue_den;
    logic [7:0]  s1_light;
    logic        s1_eof;
    logic        hdiv_valid;
    logic        sdiv_valid;
    logic [7:0]  hdiv_quo;
    logic [7:0]  sdiv_quo;
    logic        hdiv_eof;
    logic [7:0]  sdiv_light;
    hls_pix_t    div_pix;
    logic        adj_valid;
    hls_pix_t    adj_pix;
    logic        out_valid;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        out_eof;

    // Pipeline advances unless the output beat is held.
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_offset        <= '0;
            cfg_reg.lightness_adjust  <= '0;
            cfg_reg.saturation_adjust <= SAT_ADJ_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HUE_OFFSET: cfg_reg.hue_offset        <= $signed(cfg_data);
                REG_LIGHTNESS:  cfg_reg.lightness_adjust  <= $signed(cfg_data);
                REG_SATURATION: cfg_reg.saturation_adjust <= $signed(cfg_data);
                default:        cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // RGB to HLS operands.
    hsa_rgb2hls u_rgb2hls (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_red    (s_axis_tdata[7:0]),
        .in_green  (s_axis_tdata[15:8]),
        .in_blue   (s_axis_tdata[23:16]),
        .in_eof    (s_axis_tlast),
        .out_valid (s1_valid),
        .sat_num   (s1_sat_num),
        .sat_den   (s1_sat_den),
        .hue_num   (s1_hue_num),
        .hue_den   (s1_hue_den),
        .light     (s1_light),
        .eof       (s1_eof)
    );

    // Hue divider; carries the frame flag.
    hsa_div #(
        .NUM_W  (DivNumW),
        .DEN_W  (DivDenW),
        .QUO_W  (DivQuoW),
        .SIDE_W (1)
    ) u_hue_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid),
        .num       (s1_hue_num),
        .den       (s1_hue_den),
        .in_side   (s1_eof),
        .out_valid (hdiv_valid),
        .quo       (hdiv_quo),
        .out_side  (hdiv_eof)
    );

    // Saturation divider; carries the lightness.
    hsa_div #(
        .NUM_W  (DivNumW),
        .DEN_W  (DivDenW),
        .QUO_W  (DivQuoW),
        .SIDE_W (8)
    ) u_sat_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid),
        .num       (s1_sat_num),
        .den       (s1_sat_den),
        .in_side   (s1_light),
        .out_valid (sdiv_valid),
        .quo       (sdiv_quo),
        .out_side  (sdiv_light)
    );

    assign div_pix.hue   = hdiv_quo;
    assign div_pix.light = sdiv_light;
    assign div_pix.sat   = sdiv_quo;
    assign div_pix.eof   = hdiv_eof;

    // Register-controlled adjustment.
    hsa_adjust u_adjust (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (hdiv_valid && sdiv_valid),
        .in_pix    (div_pix),
        .out_valid (adj_valid),
        .out_pix   (adj_pix)
    );

    // HLS back to RGB; its last stage is the output register.
    hsa_hls2rgb u_hls2rgb (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (adj_valid),
        .in_pix    (adj_pix),
        .out_valid (out_valid),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_eof   (out_eof)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {out_blue, out_green, out_red};
    assign m_axis_tlast  = out_eof;

endmodule
